@@ src/constant_speed_step_generator_top_assert.svh @@
// Assertion macros for the step generator checker.
`ifndef CONSTANT_SPEED_STEP_GENERATOR_TOP_ASSERT_SVH
`define CONSTANT_SPEED_STEP_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CSG_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csg check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define CSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csg check failed");

`endif

@@ src/csg_pkg.sv @@
// Package: types, codes and reset values for the constant-speed step generator.
`default_nettype none
package csg_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned CntW  = 24;
  localparam int unsigned PulseW = 16;
  localparam int unsigned InvW  = 2;
  localparam int unsigned KindW = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 4;

  localparam logic [CntW-1:0]   CNT_MAX          = {CntW{1'b1}};
  localparam logic [CntW-1:0]   STEP_INTERVAL_RST = 24'd1000000;
  localparam logic [PulseW-1:0] PULSE_WIDTH_RST  = 16'd1;
  localparam logic [InvW-1:0]   PIN_INVERT_RST   = 2'b00;

  // Item kinds
  localparam logic [KindW-1:0] KIND_TICK     = 3'd0;
  localparam logic [KindW-1:0] KIND_MOVE_ABS = 3'd1;
  localparam logic [KindW-1:0] KIND_MOVE_REL = 3'd2;
  localparam logic [KindW-1:0] KIND_SET_POS  = 3'd3;
  localparam logic [KindW-1:0] KIND_STOP     = 3'd4;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_STEP_INTERVAL = 2'd0;
  localparam logic [1:0] REG_PULSE_WIDTH   = 2'd1;
  localparam logic [1:0] REG_PIN_INVERT    = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic signed [PosW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                   stepped;
    logic                   step_lvl;
    logic                   dir_pin;
    logic signed [PosW-1:0] position;
    logic                   running;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0]   step_interval;
    logic [PulseW-1:0] pulse_width;
    logic [InvW-1:0]   pin_invert;
  } cfg_t;

endpackage
`default_nettype wire

@@ src/csg_cfg.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none
module csg_cfg
  import csg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [CntW-1:0]   step_interval_r, step_interval_nxt;
  logic [PulseW-1:0] pulse_width_r, pulse_width_nxt;
  logic [InvW-1:0]   pin_invert_r, pin_invert_nxt;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    step_interval_nxt = step_interval_r;
    pulse_width_nxt   = pulse_width_r;
    pin_invert_nxt    = pin_invert_r;
    if (wr_en) begin
      case (reg_idx)
        REG_STEP_INTERVAL: step_interval_nxt = pwdata[CntW-1:0];
        REG_PULSE_WIDTH:   pulse_width_nxt   = pwdata[PulseW-1:0];
        REG_PIN_INVERT:    pin_invert_nxt    = pwdata[InvW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_interval_r <= STEP_INTERVAL_RST;
      pulse_width_r   <= PULSE_WIDTH_RST;
      pin_invert_r    <= PIN_INVERT_RST;
    end else begin
      step_interval_r <= step_interval_nxt;
      pulse_width_r   <= pulse_width_nxt;
      pin_invert_r    <= pin_invert_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEP_INTERVAL: prdata = {{(DataW-CntW){1'b0}}, step_interval_r};
      REG_PULSE_WIDTH:   prdata = {{(DataW-PulseW){1'b0}}, pulse_width_r};
      REG_PIN_INVERT:    prdata = {{(DataW-InvW){1'b0}}, pin_invert_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg.step_interval = step_interval_r;
  assign cfg.pulse_width   = pulse_width_r;
  assign cfg.pin_invert    = pin_invert_r;

endmodule
`default_nettype wire

@@ src/csg_core.sv @@
// Motion state and the single-pass update for one word.
`default_nettype none
module csg_core
  import csg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      go,
  input  in_item_t       item,
  input  cfg_t           cfg,
  output out_item_t      res
);

  logic [PosW-1:0]   cur_pos_r, cur_pos_nxt;
  logic [PosW-1:0]   tgt_pos_r, tgt_pos_nxt;
  logic [CntW-1:0]   interval_r, interval_nxt;
  logic              cw_r, cw_nxt;
  logic [CntW-1:0]   elapsed_r, elapsed_nxt;
  logic [PulseW-1:0] pulse_r, pulse_nxt;
  logic              dir_r, dir_nxt;

  logic [PosW-1:0]   val;
  logic [PosW-1:0]   rel_tgt;
  logic [PosW-1:0]   span;
  logic [CntW-1:0]   elapsed_inc;
  logic              plan_en;
  logic              stepped;

  assign val         = $unsigned(item.value);
  assign rel_tgt     = cur_pos_r + val;
  assign elapsed_inc = (elapsed_r != CNT_MAX) ? elapsed_r + 1'b1 : elapsed_r;

  always_comb begin
    cur_pos_nxt  = cur_pos_r;
    tgt_pos_nxt  = tgt_pos_r;
    interval_nxt = interval_r;
    cw_nxt       = cw_r;
    elapsed_nxt  = elapsed_r;
    pulse_nxt    = pulse_r;
    dir_nxt      = dir_r;
    span         = '0;
    plan_en      = 1'b0;
    stepped      = 1'b0;
    case (item.kind)
      KIND_TICK: begin
        if (interval_r != '0 && elapsed_inc >= interval_r) begin
          cur_pos_nxt = cw_r ? cur_pos_r + 1'b1 : cur_pos_r - 1'b1;
          elapsed_nxt = '0;
          dir_nxt     = cw_r;
          pulse_nxt   = cfg.pulse_width;
          stepped     = 1'b1;
          span        = tgt_pos_r - cur_pos_nxt;
          plan_en     = 1'b1;
        end else begin
          elapsed_nxt = elapsed_inc;
          pulse_nxt   = (pulse_r != '0) ? pulse_r - 1'b1 : pulse_r;
        end
      end
      KIND_MOVE_ABS: begin
        if (tgt_pos_r != val) begin
          tgt_pos_nxt = val;
          span        = val - cur_pos_r;
          plan_en     = 1'b1;
        end
      end
      KIND_MOVE_REL: begin
        // distance to the new target is the offset itself
        if (tgt_pos_r != rel_tgt) begin
          tgt_pos_nxt = rel_tgt;
          span        = val;
          plan_en     = 1'b1;
        end
      end
      KIND_SET_POS: begin
        cur_pos_nxt  = val;
        tgt_pos_nxt  = val;
        interval_nxt = '0;
      end
      KIND_STOP: begin
        interval_nxt = '0;
        tgt_pos_nxt  = cur_pos_r;
      end
      default: ;
    endcase
    if (plan_en) begin
      if (span == '0) begin
        interval_nxt = '0;
      end else begin
        cw_nxt       = ~span[PosW-1];
        interval_nxt = cfg.step_interval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r  <= '0;
      tgt_pos_r  <= '0;
      interval_r <= '0;
      cw_r       <= 1'b0;
      elapsed_r  <= '0;
      pulse_r    <= '0;
      dir_r      <= 1'b0;
    end else if (go) begin
      cur_pos_r  <= cur_pos_nxt;
      tgt_pos_r  <= tgt_pos_nxt;
      interval_r <= interval_nxt;
      cw_r       <= cw_nxt;
      elapsed_r  <= elapsed_nxt;
      pulse_r    <= pulse_nxt;
      dir_r      <= dir_nxt;
    end
  end

  assign res.stepped  = stepped;
  assign res.step_lvl = (pulse_nxt != '0) ^ cfg.pin_invert[0];
  assign res.dir_pin  = dir_nxt ^ cfg.pin_invert[1];
  assign res.position = $signed(cur_pos_nxt);
  assign res.running  = (tgt_pos_nxt != cur_pos_nxt);

endmodule
`default_nettype wire

@@ src/constant_speed_step_generator_top.sv @@
// Top level of the constant-speed step/direction generator.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall    in_data  (kind, value)
//   out_      output     out_valid/out_stall  out_data (stepped, pins, position, running)
//   cfg       APB write  psel/penable/pwrite  paddr[3:2] selects register
//
// One word per cycle while the output is not stalled; a word is held in the input register
// and its result is written into the output register when the core advances on it.
// The longest path is the 32-bit step increment feeding the 32-bit distance subtract.
// Reset (rst_n low, synchronous) clears position, target, timers and both stages.
// A stalled result holds; the input register keeps taking words until it is full too.
`default_nettype none
module constant_speed_step_generator_top
  import csg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  in_item_t  in_data_r;
  logic      in_valid_r, in_valid_nxt;
  out_item_t out_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t res;
  logic      go;
  logic      in_take;

  csg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  // advance when the result slot is free or being drained this cycle
  assign go       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !go;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take ? 1'b1 : (go ? 1'b0 : in_valid_r);
  assign out_valid_nxt = go ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ src/csg_checker.sv @@
// Port-level checker for the step generator, bound to the top level.
`default_nettype none
`include "constant_speed_step_generator_top_assert.svh"
module csg_checker
  import csg_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input out_item_t             out_data
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a held result keeps its word
  `CSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // input backs up only behind a stalled result
  `CSG_ASSERT(a_stall_cause, in_stall, out_valid && out_stall)

  // a new result follows an accepted word that went through the input register
  `CSG_ASSERT(a_out_source, out_valid && !$past(out_valid), $past(in_acc, 2))

endmodule

bind constant_speed_step_generator_top csg_checker u_csg_checker (.*);
`default_nettype wire

@@ tb/constant_speed_step_generator_top_tb.sv @@
// Self-checking testbench for the constant-speed step/direction generator.
`timescale 1ns / 100ps
`default_nettype none
module constant_speed_step_generator_top_tb;
  import csg_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned IDLE_PCT    = 25;
  localparam logic [KindW-1:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [KindW-1:0] KIND_SPARE_MID = 3'd6;
  localparam logic [KindW-1:0] KIND_SPARE_HI  = 3'd7;
  localparam logic [1:0]       REG_SPARE      = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  constant_speed_step_generator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  in_item_t  words_to_send[$];
  out_item_t expected_status[$];
  bit        quiet = 1'b0;
  bit        draining = 1'b0;
  int        words_sent = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;

  // Register mirror, written only while the block is idle
  logic [CntW-1:0]   cfg_interval = STEP_INTERVAL_RST;
  logic [PulseW-1:0] cfg_pulse = PULSE_WIDTH_RST;
  logic [InvW-1:0]   cfg_invert = PIN_INVERT_RST;

  // Motor state
  logic [PosW-1:0]   pos_now, pos_target;
  logic [CntW-1:0]   interval_live, elapsed;
  logic [PulseW-1:0] pulse_left;
  logic              cw, dir_q;

  function automatic void plan_move();
    logic [PosW-1:0] gap;
    gap = pos_target - pos_now;
    if (gap == '0) begin
      interval_live = '0;
    end else begin
      cw = ~gap[PosW-1];
      interval_live = cfg_interval;
    end
  endfunction

  function automatic void retarget(input logic [PosW-1:0] goal);
    if (pos_target != goal) begin
      pos_target = goal;
      plan_move();
    end
  endfunction

  function automatic out_item_t advance_motor(input in_item_t w);
    out_item_t r;
    logic [PosW-1:0] v;
    v = w.value;
    r.stepped = 1'b0;
    case (w.kind)
      KIND_TICK: begin
        if (pulse_left != '0) pulse_left = pulse_left - 1'b1;
        if (elapsed != CNT_MAX) elapsed = elapsed + 1'b1;
        if (interval_live != '0 && elapsed >= interval_live) begin
          pos_now = cw ? pos_now + 1 : pos_now - 1;
          elapsed = '0;
          dir_q = cw;
          pulse_left = cfg_pulse;
          r.stepped = 1'b1;
          plan_move();
        end
      end
      KIND_MOVE_ABS: retarget(v);
      KIND_MOVE_REL: retarget(pos_now + v);
      KIND_SET_POS: begin
        pos_now = v;
        pos_target = v;
        interval_live = '0;
      end
      KIND_STOP: begin
        interval_live = '0;
        pos_target = pos_now;
      end
      default: ;
    endcase
    r.step_lvl = (pulse_left != '0) ^ cfg_invert[0];
    r.dir_pin  = dir_q ^ cfg_invert[1];
    r.position = pos_now;
    r.running  = (pos_target != pos_now);
    return r;
  endfunction

  function automatic void report_mismatch(input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: status mismatch: expected stepped=%b step=%b dir=%b pos=%h run=%b,",
                " got stepped=%b step=%b dir=%b pos=%h run=%b"},
               $realtime, want.stepped, want.step_lvl, want.dir_pin, want.position,
               want.running, got.stepped, got.step_lvl, got.dir_pin, got.position,
               got.running);
  endfunction

  // Sender: one word in flight, refilled from the queue
  always @(posedge clk) begin : driver
    bit free;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      free = !in_valid || !in_stall;
      if (free) begin
        if (in_valid) begin
          words_sent++;
          // hold off now and then until every status word is back
          if (words_sent == 200 || $urandom_range(199) == 0) draining = 1'b1;
        end else if (draining && expected_status.size() == 0) begin
          draining = 1'b0;
        end
        if (!draining && words_to_send.size() != 0 &&
            (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data <= words_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      pos_now = '0;
      pos_target = '0;
      interval_live = '0;
      elapsed = '0;
      pulse_left = '0;
      cw = 1'b0;
      dir_q = 1'b0;
      expected_status.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: status word with nothing expected: pos=%h",
                     $realtime, out_data.position);
        end else begin
          want = expected_status.pop_front();
          if (out_data.stepped !== want.stepped || out_data.step_lvl !== want.step_lvl ||
              out_data.dir_pin !== want.dir_pin || out_data.position !== want.position ||
              out_data.running !== want.running)
            report_mismatch(want, out_data);
        end
      end
      if (in_valid && !in_stall) expected_status.push_back(advance_motor(in_data));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic queue_word(input logic [KindW-1:0] k, input logic [PosW-1:0] v);
    in_item_t w;
    w.kind = k;
    w.value = v;
    words_to_send.push_back(w);
  endtask

  function automatic logic [PosW-1:0] edge_position();
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFE;
      1: return 32'h8000_0001;
      2: return 32'hFFFF_FFFE;
      3: return 32'h0000_0002;
      default: return $urandom;
    endcase
  endfunction

  // Mostly ticks and short moves so the motor actually runs; the rest is noise
  task automatic queue_random_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) queue_word(KIND_TICK, $urandom);
    else if (r < 77) queue_word(KIND_MOVE_REL, 32'($urandom_range(16)) - 32'd8);
    else if (r < 83) queue_word(KIND_MOVE_ABS, 32'($urandom_range(40)) - 32'd20);
    else if (r < 88) queue_word(KIND_SET_POS, edge_position());
    else if (r < 92) queue_word(KIND_STOP, $urandom);
    else if (r < 95) queue_word(KIND_MOVE_ABS, $urandom);
    else if (r < 97) queue_word(KIND_MOVE_REL, $urandom);
    else queue_word(3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)), $urandom);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DataW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_STEP_INTERVAL: cfg_interval = val[CntW-1:0];
      REG_PULSE_WIDTH:   cfg_pulse = val[PulseW-1:0];
      REG_PIN_INVERT:    cfg_invert = val[InvW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_profile(input logic [DataW-1:0] interval, input logic [DataW-1:0] pulse,
                             input logic [DataW-1:0] invert);
    write_reg(REG_STEP_INTERVAL, interval);
    write_reg(REG_PULSE_WIDTH, pulse);
    write_reg(REG_PIN_INVERT, invert);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (words_to_send.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int count, input bit calm);
    quiet = calm;
    repeat (count) queue_random_word();
    wait_drained();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset profile: interval too long to step within the run
    queue_word(KIND_MOVE_ABS, 32'd5);
    queue_word(KIND_TICK, 32'd0);
    queue_word(KIND_TICK, 32'hFFFF_FFFF);
    queue_word(KIND_MOVE_ABS, 32'd5);
    queue_word(KIND_STOP, 32'd0);
    queue_word(KIND_SET_POS, 32'h7FFF_FFFF);
    queue_word(KIND_MOVE_REL, 32'd1);
    queue_word(KIND_SPARE_LO, 32'hFFFF_FFFF);
    queue_word(KIND_SPARE_MID, 32'd0);
    queue_word(KIND_SPARE_HI, 32'hAAAA_AAAA);
    queue_word(KIND_SET_POS, 32'h8000_0000);
    queue_word(KIND_MOVE_ABS, 32'h7FFF_FFFF);
    queue_word(KIND_STOP, 32'h5555_5555);
    queue_word(KIND_TICK, 32'h5555_5555);
    wait_drained();

    // Upper bits must be dropped; the spare index must change nothing
    set_profile(32'hFF00_0002, 32'hFFFF_0003, 32'hFFFF_FFFD);
    write_reg(REG_SPARE, 32'h0000_0001);
    queue_word(KIND_SET_POS, 32'hFFFF_FFFE);
    queue_word(KIND_MOVE_REL, 32'd3);
    repeat (6) queue_word(KIND_TICK, 32'd0);
    queue_word(KIND_MOVE_REL, 32'hFFFF_FFFF);
    repeat (3) queue_word(KIND_TICK, 32'd0);
    queue_word(KIND_STOP, 32'd0);
    wait_drained();

    set_profile(32'd1, 32'd1, 32'd0);
    run_random(70, 1'b0);
    set_profile(32'd3, 32'd2, 32'd2);
    run_random(80, 1'b0);
    set_profile(32'd0, 32'd4, 32'd1);
    run_random(40, 1'b0);
    set_profile(32'd5, 32'd0, 32'd0);
    run_random(70, 1'b0);
    set_profile(32'h00FF_FFFF, 32'h0000_FFFF, 32'd3);
    run_random(40, 1'b0);
    set_profile(32'd2, 32'h0000_FFFF, 32'd1);
    run_random(70, 1'b0);
    set_profile(32'd4, 32'd3, 32'd0);
    run_random(80, 1'b1);

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ constant_speed_step_generator_top.f @@
+incdir+src
src/csg_pkg.sv
src/csg_cfg.sv
src/csg_core.sv
src/constant_speed_step_generator_top.sv
src/csg_checker.sv
tb/constant_speed_step_generator_top_tb.sv
